/* design/mts_pkg.sv */
// ---------------------------------------------------------------------------
// mts_pkg
// Shared constants, codes and controller/datapath signal groups for the
// melody tone sequencer.
// ---------------------------------------------------------------------------
package mts_pkg;

  // Note table
  localparam int MAX_NOTES = 64;
  localparam int IDX_W     = $clog2(MAX_NOTES);
  localparam int COUNT_W   = $clog2(MAX_NOTES + 1);

  // Field widths
  localparam int MODE_W  = 2;
  localparam int FREQ_W  = 16;
  localparam int LEN_W   = 16;
  localparam int CODE_W  = 3;
  localparam int CMP_W   = 8;
  localparam int PLAYS_W = 8;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 1'b1;

  // Frequency bands: edges, prescaler codes, dividend factors
  localparam logic [FREQ_W-1:0] BAND_EDGE_0 = 16'd60;
  localparam logic [FREQ_W-1:0] BAND_EDGE_1 = 16'd120;
  localparam logic [FREQ_W-1:0] BAND_EDGE_2 = 16'd240;

  localparam logic [CODE_W-1:0] CODE_1024 = 3'd7;
  localparam logic [CODE_W-1:0] CODE_256  = 3'd6;
  localparam logic [CODE_W-1:0] CODE_128  = 3'd5;
  localparam logic [CODE_W-1:0] CODE_64   = 3'd4;

  localparam logic [FREQ_W-1:0] FACTOR_1024 = 16'd3906;
  localparam logic [FREQ_W-1:0] FACTOR_256  = 16'd15625;
  localparam logic [FREQ_W-1:0] FACTOR_128  = 16'd31250;
  localparam logic [FREQ_W-1:0] FACTOR_64   = 16'd62500;

  // Gap lengths in ms
  localparam logic [LEN_W-1:0] GAP_MS      = 16'd50;
  localparam logic [LEN_W-1:0] GAP_LAST_MS = 16'd250;

  localparam logic [CMP_W-1:0] CMP_MAX = 8'hFF;
  localparam logic [PLAYS_W-1:0] PLAYS_MAX = 8'hFF;

  // Divider: one quotient bit per step
  localparam int DIV_STEPS = FREQ_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic capture;    // latch input transaction fields
    logic exec;       // apply tick, load or start
    logic note_load;  // take note entry, set timing, seed divider
    logic div_step;   // one restoring division step
    logic tone_set;   // commit prescaler/compare, sound the tone
    logic out_load;   // snapshot state into result register
  } mts_cmd_t;

  typedef struct packed {
    logic exec_start; // the pending item goes on to start a note
    logic freq_zero;  // note just read is a rest
  } mts_stat_t;

endpackage

/* design/mts_item_if.sv */
// ---------------------------------------------------------------------------
// mts_item_if
// Input channel: tick, load and start transactions.
// ---------------------------------------------------------------------------
interface mts_item_if;
  logic                        valid;
  logic                        ready;
  logic [mts_pkg::MODE_W-1:0]  mode;
  logic [mts_pkg::IDX_W-1:0]   entry_index;
  logic [mts_pkg::FREQ_W-1:0]  note_freq;
  logic [mts_pkg::LEN_W-1:0]   note_length;

  modport source (output valid, mode, entry_index, note_freq, note_length, input ready);
  modport sink   (input valid, mode, entry_index, note_freq, note_length, output ready);
endinterface

/* design/mts_result_if.sv */
// ---------------------------------------------------------------------------
// mts_result_if
// Output channel: tone timer settings and play status.
// ---------------------------------------------------------------------------
interface mts_result_if;
  logic                        valid;
  logic                        ready;
  logic                        tone_enable;
  logic [mts_pkg::CODE_W-1:0]  clock_select;
  logic [mts_pkg::CMP_W-1:0]   compare_top;
  logic                        playing;
  logic [mts_pkg::IDX_W-1:0]   current_note;

  modport source (output valid, tone_enable, clock_select, compare_top, playing,
                  current_note, input ready);
  modport sink   (input valid, tone_enable, clock_select, compare_top, playing,
                  current_note, output ready);
endinterface

/* design/melody_tone_sequencer.sv */
// ---------------------------------------------------------------------------
// melody_tone_sequencer
// Stored-melody player: note table, millisecond countdown and tone timer
// prescaler/compare set-up, one result transaction per input transaction.
// ---------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  item      in    valid/ready        mode, entry_index, note_freq, note_length
//  result    out   valid/ready        tone_enable, clock_select, compare_top,
//                                     playing, current_note
//  cfg       in    cfg_we (no stall)  cfg_index, cfg_data
//
//  One item at a time. An item that starts no note goes from execute straight
//  to the result; one that starts a rest also reads its note; one that starts a
//  tone also runs the 16-step restoring divider that forms the compare value.
//  No new item is taken until the current one has handed off its result.
//  rst is synchronous: note count 0, repeat count 1, nothing playing.
//  The table contents are undefined until loaded.
//  A result waiting on a stalled sink does not block the next item; the
//  sequencer stalls only when a second result is ready before the first goes.
// ---------------------------------------------------------------------------
module melody_tone_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mts_pkg::CFG_W-1:0]      cfg_data,
  mts_item_if.sink                       item,
  mts_result_if.source                   result
);

  mts_pkg::mts_cmd_t  cmd;   // controller -> datapath
  mts_pkg::mts_stat_t st;    // datapath -> controller

  // Sequencing: accept, execute, optional note read + divide, hand-off
  mts_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .st           (st),
    .cmd          (cmd)
  );

  // All architectural state, the note table and the divider live here
  mts_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (item.mode),
    .entry_index  (item.entry_index),
    .note_freq    (item.note_freq),
    .note_length  (item.note_length),
    .cmd          (cmd),
    .st           (st),
    .tone_enable  (result.tone_enable),
    .clock_select (result.clock_select),
    .compare_top  (result.compare_top),
    .playing      (result.playing),
    .current_note (result.current_note)
  );

endmodule

/* design/mts_ctrl.sv */
// ---------------------------------------------------------------------------
// mts_ctrl
// Sequencing FSM: accept, execute, note read, divide, result hand-off.
// ---------------------------------------------------------------------------
module mts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  output logic                result_valid,
  input  logic                result_ready,
  input  mts_pkg::mts_stat_t  st,
  output mts_pkg::mts_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_READ, S_NOTE, S_DIV, S_TONE, S_DONE
  } state_t;

  state_t                          state;
  logic [mts_pkg::DIV_CNT_W-1:0]   div_cnt;
  logic                            out_free;

  assign item_ready = (state == S_IDLE);
  assign out_free   = !result_valid || result_ready;

  always_comb begin
    cmd           = '0;
    cmd.capture   = (state == S_IDLE) && item_valid;
    cmd.exec      = (state == S_EXEC);
    cmd.note_load = (state == S_NOTE);
    cmd.div_step  = (state == S_DIV);
    cmd.tone_set  = (state == S_TONE);
    cmd.out_load  = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      div_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= st.exec_start ? S_READ : S_DONE;
        end
        S_READ: begin
          state <= S_NOTE;
        end
        S_NOTE: begin
          div_cnt <= '0;
          state   <= st.freq_zero ? S_DONE : S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == mts_pkg::DIV_CNT_W'(mts_pkg::DIV_STEPS - 1)) state <= S_TONE;
        end
        S_TONE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // new result loads as the old one leaves
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/mts_datapath.sv */
// ---------------------------------------------------------------------------
// mts_datapath
// Note table, play state, timing counter, compare divider, result register.
// ---------------------------------------------------------------------------
module mts_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mts_pkg::CFG_W-1:0]         cfg_data,
  input  logic [mts_pkg::MODE_W-1:0]        mode,
  input  logic [mts_pkg::IDX_W-1:0]         entry_index,
  input  logic [mts_pkg::FREQ_W-1:0]        note_freq,
  input  logic [mts_pkg::LEN_W-1:0]         note_length,
  input  mts_pkg::mts_cmd_t                 cmd,
  output mts_pkg::mts_stat_t                st,
  output logic                              tone_enable,
  output logic [mts_pkg::CODE_W-1:0]        clock_select,
  output logic [mts_pkg::CMP_W-1:0]         compare_top,
  output logic                              playing,
  output logic [mts_pkg::IDX_W-1:0]         current_note
);

  // Note table: {freq, length}
  logic [mts_pkg::FREQ_W+mts_pkg::LEN_W-1:0] note_mem [mts_pkg::MAX_NOTES];
  logic [mts_pkg::FREQ_W+mts_pkg::LEN_W-1:0] rd_data;
  logic [mts_pkg::FREQ_W-1:0]                rd_freq;
  logic [mts_pkg::LEN_W-1:0]                 rd_len;

  // Captured transaction
  logic [mts_pkg::MODE_W-1:0]  mode_q;
  logic [mts_pkg::IDX_W-1:0]   idx_q;
  logic [mts_pkg::FREQ_W-1:0]  freq_q;
  logic [mts_pkg::LEN_W-1:0]   len_q;

  // Configuration
  logic [mts_pkg::COUNT_W-1:0] note_count;
  logic [mts_pkg::PLAYS_W-1:0] repeat_count;

  // Play state
  logic [mts_pkg::LEN_W-1:0]   time_left;
  logic                        hold_forever;
  logic                        tone_phase;
  logic [mts_pkg::IDX_W-1:0]   note_pointer;
  logic [mts_pkg::PLAYS_W-1:0] plays_done;
  logic                        active;
  logic [mts_pkg::CODE_W-1:0]  prescale_reg;
  logic [mts_pkg::CMP_W-1:0]   compare_reg;

  // Divider
  logic [mts_pkg::CODE_W-1:0]  band;
  logic [mts_pkg::FREQ_W-1:0]  divisor;
  logic [mts_pkg::FREQ_W-1:0]  rem;
  logic [mts_pkg::FREQ_W-1:0]  quot;
  logic [mts_pkg::FREQ_W:0]    div_sh;
  logic [mts_pkg::FREQ_W+1:0]  div_diff;

  // Tick decisions
  logic [mts_pkg::COUNT_W-1:0] n_eff;
  logic [mts_pkg::COUNT_W-1:0] np_inc;
  logic                        wrap;
  logic [mts_pkg::PLAYS_W-1:0] pd_new;
  logic                        tick_live;
  logic [mts_pkg::LEN_W-1:0]   tl_dec;
  logic                        tl_zero;
  logic                        last_note;
  logic [mts_pkg::CODE_W-1:0]  band_code;
  logic [mts_pkg::FREQ_W-1:0]  band_factor;

  assign rd_freq = rd_data[mts_pkg::FREQ_W+mts_pkg::LEN_W-1:mts_pkg::LEN_W];
  assign rd_len  = rd_data[mts_pkg::LEN_W-1:0];

  assign n_eff = (note_count > mts_pkg::COUNT_W'(mts_pkg::MAX_NOTES))
               ? mts_pkg::COUNT_W'(mts_pkg::MAX_NOTES) : note_count;
  assign np_inc    = {1'b0, note_pointer} + 1'b1;
  assign wrap      = (np_inc >= n_eff);
  assign last_note = wrap;
  assign pd_new    = (wrap && plays_done != mts_pkg::PLAYS_MAX) ? plays_done + 1'b1
                                                               : plays_done;
  assign tick_live = active && !hold_forever;
  assign tl_dec    = (time_left != '0) ? time_left - 1'b1 : time_left;
  assign tl_zero   = (tl_dec == '0);

  always_comb begin
    st.exec_start = 1'b0;
    if (mode_q == mts_pkg::MODE_START) begin
      st.exec_start = (n_eff != '0);
    end else if (mode_q == mts_pkg::MODE_TICK) begin
      st.exec_start = tick_live && tl_zero && !tone_phase && (n_eff != '0)
                    && (pd_new < repeat_count);
    end
    st.freq_zero = (rd_freq == '0);
  end

  // Band select for the note just read
  always_comb begin
    priority if (rd_freq < mts_pkg::BAND_EDGE_0) begin
      band_code   = mts_pkg::CODE_1024;
      band_factor = mts_pkg::FACTOR_1024;
    end else if (rd_freq < mts_pkg::BAND_EDGE_1) begin
      band_code   = mts_pkg::CODE_256;
      band_factor = mts_pkg::FACTOR_256;
    end else if (rd_freq < mts_pkg::BAND_EDGE_2) begin
      band_code   = mts_pkg::CODE_128;
      band_factor = mts_pkg::FACTOR_128;
    end else begin
      band_code   = mts_pkg::CODE_64;
      band_factor = mts_pkg::FACTOR_64;
    end
  end

  // Restoring division, quotient bits shift in from the right
  assign div_sh   = {rem, quot[mts_pkg::FREQ_W-1]};
  assign div_diff = {1'b0, div_sh} - {2'b00, divisor};

  // Table: write on load, read at the note pointer every cycle
  always_ff @(posedge clk) begin
    if (cmd.exec && mode_q == mts_pkg::MODE_LOAD
        && {1'b0, idx_q} < mts_pkg::COUNT_W'(mts_pkg::MAX_NOTES)) begin
      note_mem[idx_q] <= {freq_q, len_q};
    end
    rd_data <= note_mem[note_pointer];
  end

  // Transaction capture, divider and result register (no reset needed)
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      idx_q  <= entry_index;
      freq_q <= note_freq;
      len_q  <= note_length;
    end
    if (cmd.note_load) begin
      band    <= band_code;
      divisor <= rd_freq;
      rem     <= '0;
      quot    <= band_factor;
    end else if (cmd.div_step) begin
      if (!div_diff[mts_pkg::FREQ_W+1]) begin
        rem  <= div_diff[mts_pkg::FREQ_W-1:0];
        quot <= {quot[mts_pkg::FREQ_W-2:0], 1'b1};
      end else begin
        rem  <= div_sh[mts_pkg::FREQ_W-1:0];
        quot <= {quot[mts_pkg::FREQ_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      tone_enable  <= tone_phase;
      clock_select <= prescale_reg;
      compare_top  <= compare_reg;
      playing      <= active;
      current_note <= note_pointer;
    end
  end

  // Configuration and play state
  always_ff @(posedge clk) begin
    if (rst) begin
      note_count   <= '0;
      repeat_count <= mts_pkg::PLAYS_W'(1);
      time_left    <= '0;
      hold_forever <= 1'b0;
      tone_phase   <= 1'b0;
      note_pointer <= '0;
      plays_done   <= '0;
      active       <= 1'b0;
      prescale_reg <= '0;
      compare_reg  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mts_pkg::REG_NOTE_COUNT:   note_count   <= cfg_data[mts_pkg::COUNT_W-1:0];
          mts_pkg::REG_REPEAT_COUNT: repeat_count <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.exec) begin
        unique case (mode_q)
          mts_pkg::MODE_TICK: begin
            if (tick_live) begin
              if (tl_zero && tone_phase) begin
                tone_phase <= 1'b0;
                time_left  <= last_note ? mts_pkg::GAP_LAST_MS : mts_pkg::GAP_MS;
              end else begin
                time_left <= tl_dec;
                if (tl_zero) begin
                  if (n_eff == '0) begin
                    active <= 1'b0;
                  end else begin
                    note_pointer <= wrap ? '0 : np_inc[mts_pkg::IDX_W-1:0];
                    plays_done   <= pd_new;
                    if (!(pd_new < repeat_count)) active <= 1'b0;
                  end
                end
              end
            end
          end
          mts_pkg::MODE_START: begin
            note_pointer <= '0;
            plays_done   <= '0;
            tone_phase   <= 1'b0;
            if (n_eff != '0) active <= 1'b1;
          end
          default: ;
        endcase
      end

      if (cmd.note_load) begin
        tone_phase <= 1'b0;
        if (rd_len != '0) begin
          time_left    <= rd_len;
          hold_forever <= 1'b0;
        end else begin
          time_left    <= '0;
          hold_forever <= 1'b1;
        end
      end

      if (cmd.tone_set) begin
        prescale_reg <= band;
        compare_reg  <= (quot[mts_pkg::FREQ_W-1:mts_pkg::CMP_W] != '0)
                      ? mts_pkg::CMP_MAX : quot[mts_pkg::CMP_W-1:0];
        tone_phase   <= 1'b1;
      end
    end
  end

endmodule
